>>> rtl/core/apd_pkg.sv
`default_nettype none

package apd_pkg;

  localparam int HOLD_BITS     = 10;
  localparam int THR_BITS      = 11;
  localparam int DEPTH_BITS    = 13;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 13;

  localparam logic [HOLD_BITS-1:0] HOLD_MAX = 10'd1023;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  localparam logic [HOLD_BITS-1:0]         RST_HOLD_FRAMES    = 10'd15;
  localparam logic signed [THR_BITS-1:0]   RST_SE_DY_MAX      = 11'sd60;
  localparam logic signed [THR_BITS-1:0]   RST_SE_DX_MIN      = 11'sd30;
  localparam logic [THR_BITS-2:0]          RST_HE_DX_MAX      = 10'd50;
  localparam logic signed [THR_BITS-1:0]   RST_HE_DY_MIN      = 11'sd20;
  localparam logic [DEPTH_BITS-1:0]        RST_HAND_DEPTH_MIN = 13'd700;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_HOLD_FRAMES    = 3'd0,
    CFG_SE_DY_MAX      = 3'd1,
    CFG_SE_DX_MIN      = 3'd2,
    CFG_HE_DX_MAX      = 3'd3,
    CFG_HE_DY_MIN      = 3'd4,
    CFG_HAND_DEPTH_MIN = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [HOLD_BITS-1:0]        hold_frames;
    logic signed [THR_BITS-1:0]  se_dy_max;
    logic signed [THR_BITS-1:0]  se_dx_min;
    logic [THR_BITS-2:0]         he_dx_max;
    logic signed [THR_BITS-1:0]  he_dy_min;
    logic [DEPTH_BITS-1:0]       hand_depth_min;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/arm_pose_hold_detector.sv
// Arm pose hold detector.
// Path: front register, queue, stage-1 register, output register.
// Throughput: one word per cycle when not stalled; set by the running-sum
// update of the window store (one write port, one prefetched read).
// Reset: synchronous active-low rst_n; config registers return to defaults, sums,
// counts and hold counter clear; window store is not cleared.
`default_nettype none

module arm_pose_hold_detector #(
  parameter int WINDOW_DEPTH = 20,
  parameter int COORD_BITS   = 10
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_frame_valid,
  input  wire logic [COORD_BITS-1:0]                in_shoulder_x,
  input  wire logic [COORD_BITS-1:0]                in_shoulder_y,
  input  wire logic [COORD_BITS-1:0]                in_elbow_x,
  input  wire logic [COORD_BITS-1:0]                in_elbow_y,
  input  wire logic [COORD_BITS-1:0]                in_hand_x,
  input  wire logic [COORD_BITS-1:0]                in_hand_y,
  input  wire logic [apd_pkg::DEPTH_BITS-1:0]       in_hand_depth,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      out_stop_detected,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [apd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [apd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int IW = 2 + COORD_BITS + 3 * (COORD_BITS + 1);

  apd_pkg::cfg_t     cfg_r;
  apd_pkg::q_stat_t  q_stat;
  logic              q_push;
  logic              q_pop;
  logic [IW-1:0]     q_wdata;
  logic [IW-1:0]     q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_frames    <= apd_pkg::RST_HOLD_FRAMES;
      cfg_r.se_dy_max      <= apd_pkg::RST_SE_DY_MAX;
      cfg_r.se_dx_min      <= apd_pkg::RST_SE_DX_MIN;
      cfg_r.he_dx_max      <= apd_pkg::RST_HE_DX_MAX;
      cfg_r.he_dy_min      <= apd_pkg::RST_HE_DY_MIN;
      cfg_r.hand_depth_min <= apd_pkg::RST_HAND_DEPTH_MIN;
    end else if (cfg_valid && cfg_ready) begin
      case (apd_pkg::cfg_idx_t'(cfg_index))
        apd_pkg::CFG_HOLD_FRAMES:    cfg_r.hold_frames    <= cfg_data[9:0];
        apd_pkg::CFG_SE_DY_MAX:      cfg_r.se_dy_max      <= $signed(cfg_data[10:0]);
        apd_pkg::CFG_SE_DX_MIN:      cfg_r.se_dx_min      <= $signed(cfg_data[10:0]);
        apd_pkg::CFG_HE_DX_MAX:      cfg_r.he_dx_max      <= cfg_data[9:0];
        apd_pkg::CFG_HE_DY_MIN:      cfg_r.he_dy_min      <= $signed(cfg_data[10:0]);
        apd_pkg::CFG_HAND_DEPTH_MIN: cfg_r.hand_depth_min <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  apd_front #(
    .COORD_BITS (COORD_BITS),
    .IW         (IW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_frame_valid (in_frame_valid),
    .in_shoulder_x  (in_shoulder_x),
    .in_shoulder_y  (in_shoulder_y),
    .in_elbow_x     (in_elbow_x),
    .in_elbow_y     (in_elbow_y),
    .in_hand_x      (in_hand_x),
    .in_hand_y      (in_hand_y),
    .in_hand_depth  (in_hand_depth),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  apd_queue #(
    .WIDTH (IW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  apd_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .COORD_BITS   (COORD_BITS),
    .IW           (IW)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_stat            (q_stat),
    .q_pop             (q_pop),
    .q_data            (q_rdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_stop_detected (out_stop_detected)
  );

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_stat.full)
    else $error("input stalled while queue has room");

  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

  a_no_detect_at_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stop_detected) |-> (cfg_r.hold_frames != apd_pkg::HOLD_MAX))
    else $error("detection with unreachable hold threshold");
`endif

endmodule

`default_nettype wire

>>> rtl/core/apd_front.sv
`default_nettype none

module apd_front #(
  parameter int COORD_BITS = 10,
  parameter int IW         = 2 + COORD_BITS + 3 * (COORD_BITS + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire apd_pkg::cfg_t                     cfg,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_frame_valid,
  input  wire logic [COORD_BITS-1:0]             in_shoulder_x,
  input  wire logic [COORD_BITS-1:0]             in_shoulder_y,
  input  wire logic [COORD_BITS-1:0]             in_elbow_x,
  input  wire logic [COORD_BITS-1:0]             in_elbow_y,
  input  wire logic [COORD_BITS-1:0]             in_hand_x,
  input  wire logic [COORD_BITS-1:0]             in_hand_y,
  input  wire logic [apd_pkg::DEPTH_BITS-1:0]    in_hand_depth,
  input  wire apd_pkg::q_stat_t                  q_stat,
  output logic                                   q_push,
  output logic [IW-1:0]                          q_data
);

  localparam int OW = COORD_BITS + 1;

  logic                    valid_r;
  logic [IW-1:0]           item_r;
  logic                    load;
  logic signed [OW-1:0]    hedx_s;
  logic [COORD_BITS-1:0]   hedx;
  logic signed [OW-1:0]    hedy;
  logic signed [OW-1:0]    sedy;
  logic signed [OW-1:0]    sedx;
  logic                    depth_ok;

  assign in_stall = valid_r && q_stat.full;
  assign load     = in_valid && !in_stall;
  assign q_push   = valid_r && !q_stat.full;
  assign q_data   = item_r;

  always_comb begin
    hedx_s   = $signed({1'b0, in_hand_x}) - $signed({1'b0, in_elbow_x});
    hedx     = hedx_s[OW-1] ? COORD_BITS'(-hedx_s) : hedx_s[COORD_BITS-1:0];
    hedy     = $signed({1'b0, in_hand_y}) - $signed({1'b0, in_elbow_y});
    sedy     = $signed({1'b0, in_elbow_y}) - $signed({1'b0, in_shoulder_y});
    sedx     = $signed({1'b0, in_shoulder_x}) - $signed({1'b0, in_elbow_x});
    depth_ok = in_hand_depth > cfg.hand_depth_min;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (q_push) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= {in_frame_valid, depth_ok, hedx, hedy, sedy, sedx};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/apd_queue.sv
`default_nettype none

module apd_queue #(
  parameter int WIDTH = 45
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [WIDTH-1:0]  push_data,
  input  wire logic              pop,
  output logic [WIDTH-1:0]       pop_data,
  output apd_pkg::q_stat_t       stat
);

  logic [WIDTH-1:0]              mem [apd_pkg::Q_DEPTH];
  logic [apd_pkg::Q_AW-1:0]      wr_ptr_r;
  logic [apd_pkg::Q_AW-1:0]      rd_ptr_r;
  logic [apd_pkg::Q_CW-1:0]      count_r;
  logic                          do_push;
  logic                          do_pop;

  assign stat.full  = count_r == apd_pkg::Q_CW'(apd_pkg::Q_DEPTH);
  assign stat.empty = count_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/apd_back.sv
`default_nettype none

module apd_back #(
  parameter int WINDOW_DEPTH = 20,
  parameter int COORD_BITS   = 10,
  parameter int IW           = 2 + COORD_BITS + 3 * (COORD_BITS + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire apd_pkg::cfg_t       cfg,
  input  wire apd_pkg::q_stat_t    q_stat,
  output logic                     q_pop,
  input  wire logic [IW-1:0]       q_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_stop_detected
);

  localparam int OW = COORD_BITS + 1;
  localparam int NW = $clog2(WINDOW_DEPTH + 1);
  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SW = OW + NW;
  localparam int PW = apd_pkg::THR_BITS + NW + 1;
  localparam int CW = ((SW > PW) ? SW : PW) + 1;
  localparam int EW = 4 * OW;
  localparam logic [NW-1:0] N_FULL    = NW'(WINDOW_DEPTH);
  localparam logic [AW-1:0] SLOT_LAST = AW'(WINDOW_DEPTH - 1);

  logic [EW-1:0]                   mem [WINDOW_DEPTH];
  logic [EW-1:0]                   old_r;
  logic [AW-1:0]                   slot_r;
  logic [NW-1:0]                   n_r;
  logic signed [SW-1:0]            sum_r [4];
  logic signed [PW-1:0]            prod_r [4];
  logic                            s1_valid_r;
  logic                            s1_fv_r;
  logic                            s1_dok_r;
  logic                            out_valid_r;
  logic                            out_stop_r;
  logic [apd_pkg::HOLD_BITS-1:0]   hold_r;

  logic                            en;
  logic                            item_fv;
  logic                            item_dok;
  logic                            wr_en;
  logic                            full;
  logic [AW-1:0]                   slot_nxt;
  logic [NW-1:0]                   n_nxt;
  logic [EW-1:0]                   new_entry;
  logic signed [OW-1:0]            new_ofs [4];
  logic signed [OW-1:0]            old_ofs [4];
  logic signed [SW-1:0]            sum_nxt [4];
  logic signed [PW-1:0]            prod_nxt [4];
  logic signed [apd_pkg::THR_BITS-1:0] thr [4];
  logic signed [PW-1:0]            thr_w;
  logic signed [PW-1:0]            n_w;
  logic signed [CW-1:0]            sum_c [4];
  logic signed [CW-1:0]            prod_c [4];
  logic                            pass;
  logic [apd_pkg::HOLD_BITS-1:0]   hold_nxt;

  assign en       = !out_valid_r || !out_stall;
  assign q_pop    = en && !q_stat.empty;
  assign item_fv  = q_data[IW-1];
  assign item_dok = q_data[IW-2];
  assign wr_en    = q_pop && item_fv;
  assign full     = n_r == N_FULL;
  assign slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
  assign n_nxt    = full ? n_r : n_r + 1'b1;

  // lane 0: |hand-elbow dx|, 1: hand-elbow dy, 2: elbow-shoulder dy, 3: shoulder-elbow dx
  always_comb begin
    new_ofs[0] = $signed({1'b0, q_data[3*OW +: COORD_BITS]});
    new_ofs[1] = $signed(q_data[2*OW +: OW]);
    new_ofs[2] = $signed(q_data[OW +: OW]);
    new_ofs[3] = $signed(q_data[0 +: OW]);
    new_entry  = {new_ofs[3], new_ofs[2], new_ofs[1], new_ofs[0]};
    thr[0] = $signed({1'b0, cfg.he_dx_max});
    thr[1] = cfg.he_dy_min;
    thr[2] = cfg.se_dy_max;
    thr[3] = cfg.se_dx_min;
    n_w    = PW'($signed({1'b0, n_nxt}));
    thr_w  = '0;
    for (int k = 0; k < 4; k++) begin
      old_ofs[k]  = $signed(old_r[k*OW +: OW]);
      sum_nxt[k]  = sum_r[k] - (full ? SW'(old_ofs[k]) : SW'(0)) + SW'(new_ofs[k]);
      thr_w       = PW'(thr[k]);
      prod_nxt[k] = thr_w * n_w;
      sum_c[k]    = CW'(sum_r[k]);
      prod_c[k]   = CW'(prod_r[k]);
    end
    pass = (sum_c[0] < prod_c[0]) && (sum_c[2] < prod_c[2]) &&
           (sum_c[3] > prod_c[3]) && (sum_c[1] > prod_c[1]) && s1_dok_r;
    if (!pass) begin
      hold_nxt = '0;
    end else if (hold_r == apd_pkg::HOLD_MAX) begin
      hold_nxt = hold_r;
    end else begin
      hold_nxt = hold_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      n_r         <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hold_r      <= '0;
      for (int k = 0; k < 4; k++) begin
        sum_r[k] <= '0;
      end
    end else begin
      if (wr_en) begin
        slot_r <= slot_nxt;
        n_r    <= n_nxt;
        for (int k = 0; k < 4; k++) begin
          sum_r[k] <= sum_nxt[k];
        end
      end
      if (en) begin
        s1_valid_r  <= q_pop;
        out_valid_r <= s1_valid_r;
        if (s1_valid_r && s1_fv_r) begin
          hold_r <= hold_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_fv_r  <= item_fv;
      s1_dok_r <= item_dok;
      for (int k = 0; k < 4; k++) begin
        prod_r[k] <= prod_nxt[k];
      end
    end
    if (en) begin
      out_stop_r <= s1_valid_r && s1_fv_r && pass && (hold_nxt > cfg.hold_frames);
    end
  end

  // window store; old_r prefetches the entry the next push will evict
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot_r] <= new_entry;
      old_r       <= (slot_nxt == slot_r) ? new_entry : mem[slot_nxt];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_stop_detected = out_stop_r;

endmodule

`default_nettype wire
